// ===== hw/rtl/fpa_pkg.sv =====
package fpa_pkg;

    // Q24.8 word format
    localparam int WORD_W        = 32;
    localparam int FRACTION_BITS = 8;

    // Divider sizing: numerator is 2*(|a| << F) + |b|, divisor is 2*|b|
    localparam int NUM_W = WORD_W + FRACTION_BITS + 1;
    localparam int DEN_W = WORD_W + 1;
    localparam int REM_W = DEN_W + 1;
    localparam int PROD_W = 2 * WORD_W;

    // One divider cell per numerator bit
    localparam int NUM_CELLS = NUM_W;

    // Rounding constant for the product: half of one LSB after the shift
    localparam logic [PROD_W-1:0] MUL_ROUND = PROD_W'(1) << (FRACTION_BITS - 1);

    typedef enum logic [3:0] {
        ACT_ADD   = 4'd0,
        ACT_SUB   = 4'd1,
        ACT_MUL   = 4'd2,
        ACT_DIV   = 4'd3,
        ACT_INC   = 4'd4,
        ACT_DEC   = 4'd5,
        ACT_MIN   = 4'd6,
        ACT_MAX   = 4'd7,
        ACT_TOINT = 4'd8
    } act_t;

    // How the output stage forms the final value
    typedef enum logic [1:0] {
        KIND_PLAIN,
        KIND_MUL,
        KIND_DIV
    } kind_t;

    typedef struct packed {
        logic [3:0]               action;
        logic signed [WORD_W-1:0] operand_a;
        logic signed [WORD_W-1:0] operand_b;
    } alu_req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] result_value;
        logic                     a_less;
        logic                     a_equal;
        logic                     a_greater;
        logic                     divide_by_zero;
    } alu_rsp_t;

    // Record carried down the cell chain
    typedef struct packed {
        kind_t              kind;
        logic [WORD_W-1:0]  value;
        logic               less;
        logic               equal;
        logic               greater;
        logic               dbz;
        logic               neg;
        logic [PROD_W-1:0]  prod;
        logic [NUM_W-1:0]   num;
        logic [DEN_W-1:0]   den;
        logic [REM_W-1:0]   rem;
        logic [WORD_W-1:0]  quo;
    } stage_t;

endpackage

// ===== hw/rtl/fpa_front.sv =====
module fpa_front
    import fpa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  alu_req_t req,
    output logic     stg_valid,
    input  logic     stg_ready,
    output stage_t   stg
);

    logic              valid_reg;
    stage_t            rec_reg;
    stage_t            rec_next;
    logic [WORD_W-1:0] a_u;
    logic [WORD_W-1:0] b_u;
    logic [WORD_W-1:0] mag_a;
    logic [WORD_W-1:0] mag_b;
    logic              a_lt_b;
    logic              b_lt_a;

    assign req_ready = !valid_reg || stg_ready;
    assign stg_valid = valid_reg;
    assign stg       = rec_reg;

    // Decode, magnitudes, compare flags, simple ops, the product and the divider operands
    always_comb
    begin
        a_u    = WORD_W'(req.operand_a);
        b_u    = WORD_W'(req.operand_b);
        mag_a  = a_u[WORD_W-1] ? (~a_u + WORD_W'(1)) : a_u;
        mag_b  = b_u[WORD_W-1] ? (~b_u + WORD_W'(1)) : b_u;
        a_lt_b = $signed(req.operand_a) < $signed(req.operand_b);
        b_lt_a = $signed(req.operand_b) < $signed(req.operand_a);

        rec_next         = '0;
        rec_next.kind    = KIND_PLAIN;
        rec_next.less    = a_lt_b;
        rec_next.equal   = (a_u == b_u);
        rec_next.greater = b_lt_a;
        rec_next.neg     = a_u[WORD_W-1] ^ b_u[WORD_W-1];
        rec_next.prod    = PROD_W'(mag_a) * PROD_W'(mag_b);
        rec_next.num     = {mag_a, (FRACTION_BITS + 1)'(0)} + NUM_W'(mag_b);
        rec_next.den     = {mag_b, 1'b0};
        rec_next.rem     = '0;
        rec_next.quo     = '0;

        unique case (req.action)
            ACT_ADD:   rec_next.value = a_u + b_u;
            ACT_SUB:   rec_next.value = a_u - b_u;
            ACT_MUL:   rec_next.kind  = KIND_MUL;
            ACT_DIV:
            begin
                rec_next.kind = KIND_DIV;
                rec_next.dbz  = (mag_b == '0);
            end
            ACT_INC:   rec_next.value = a_u + WORD_W'(1);
            ACT_DEC:   rec_next.value = a_u - WORD_W'(1);
            ACT_MIN:   rec_next.value = b_lt_a ? b_u : a_u;
            ACT_MAX:   rec_next.value = a_lt_b ? b_u : a_u;
            ACT_TOINT: rec_next.value = WORD_W'(req.operand_a >>> FRACTION_BITS);
            default:   rec_next.value = '0;
        endcase
    end

    // Stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (req_ready)
            valid_reg <= req_valid;
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            rec_reg <= rec_next;
    end

endmodule

// ===== hw/rtl/fpa_cell.sv =====
module fpa_cell
    import fpa_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   up_valid,
    output logic   up_ready,
    input  stage_t up,
    output logic   dn_valid,
    input  logic   dn_ready,
    output stage_t dn
);

    logic             valid_reg;
    stage_t           rec_reg;
    stage_t           rec_next;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W:0]   diff;
    logic             qbit;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn       = rec_reg;

    // One restoring divide step: bring down a numerator bit, try the subtract
    always_comb
    begin
        rem_sh   = {up.rem[REM_W-2:0], up.num[NUM_W-1]};
        diff     = {1'b0, rem_sh} - (REM_W + 1)'(up.den);
        qbit     = !diff[REM_W];
        rec_next = up;
        rec_next.rem = qbit ? diff[REM_W-1:0] : rem_sh;
        rec_next.num = {up.num[NUM_W-2:0], 1'b0};
        rec_next.quo = {up.quo[WORD_W-2:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            rec_reg <= rec_next;
    end

endmodule

// ===== hw/rtl/fixed_point_q24_8_alu_core.sv =====
// Signed Q24.8 fixed-point ALU.
// Request channel (req_valid/req_ready/req): one transfer carries an action
// code and two raw operands. Response channel (rsp_valid/rsp_ready/rsp): one
// transfer per request, in request order, with the raw result and the
// less/equal/greater and divide-by-zero flags.
// Every action goes through the same pipeline: a front stage (decode, simple
// ops, 32x32 magnitude product), a chain of 41 divider cells (one restoring
// quotient bit each, NUM_W = 32 + fraction bits + 1), and an output register
// that applies rounding and sign. Throughput is one request per cycle while
// rsp_ready stays high. Each stage holds its own valid bit, so bubbles
// collapse: when the receiver stalls, items keep moving until the chain is
// full, and req_ready drops only then. Results wrap modulo 2^32; divide by
// zero returns 0 with its flag. Reset clears all valid bits; no response is
// pending after reset.
module fixed_point_q24_8_alu_core
    import fpa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  alu_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output alu_rsp_t rsp
);

    logic   chain_valid [NUM_CELLS+1];
    logic   chain_ready [NUM_CELLS+1];
    stage_t chain_rec   [NUM_CELLS+1];

    logic              rsp_valid_reg;
    alu_rsp_t          rsp_reg;
    alu_rsp_t          rsp_next;
    stage_t            last;
    logic [PROD_W-1:0] mul_sum;
    logic [WORD_W-1:0] mag;

    // Front stage
    fpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .stg_valid (chain_valid[0]),
        .stg_ready (chain_ready[0]),
        .stg       (chain_rec[0])
    );

    // Divider cell chain
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        fpa_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[i]),
            .up_ready (chain_ready[i]),
            .up       (chain_rec[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_ready (chain_ready[i+1]),
            .dn       (chain_rec[i+1])
        );
    end

    assign chain_ready[NUM_CELLS] = !rsp_valid_reg || rsp_ready;
    assign last = chain_rec[NUM_CELLS];

    // Final rounding and sign
    always_comb
    begin
        mul_sum = last.prod + MUL_ROUND;
        mag     = (last.kind == KIND_MUL) ? mul_sum[FRACTION_BITS +: WORD_W] : last.quo;

        rsp_next.a_less         = last.less;
        rsp_next.a_equal        = last.equal;
        rsp_next.a_greater      = last.greater;
        rsp_next.divide_by_zero = last.dbz;

        unique case (last.kind)
            KIND_MUL: rsp_next.result_value = last.neg ? (~mag + WORD_W'(1)) : mag;
            KIND_DIV:
            begin
                if (last.dbz)
                    rsp_next.result_value = '0;
                else
                    rsp_next.result_value = last.neg ? (~mag + WORD_W'(1)) : mag;
            end
            default:  rsp_next.result_value = last.value;
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (chain_ready[NUM_CELLS])
            rsp_valid_reg <= chain_valid[NUM_CELLS];
    end

    always_ff @(posedge clk)
    begin
        if (chain_valid[NUM_CELLS] && chain_ready[NUM_CELLS])
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Exactly one compare flag is set
    a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $onehot({rsp.a_less, rsp.a_equal, rsp.a_greater}))
        else $error("compare flags not one-hot");

    // Divide by zero returns zero
    a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.divide_by_zero) |-> (rsp.result_value == '0))
        else $error("divide by zero result not zero");

    // Divide by zero only with a zero divisor at the end of the chain
    a_dbz_div: assert property (@(posedge clk) disable iff (!rst_n)
        (chain_valid[NUM_CELLS] && last.dbz) |-> (last.kind == KIND_DIV && last.den == '0))
        else $error("divide by zero flag on wrong item");

    // Equal flag agrees with the sign of the compare
    a_eq_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (chain_valid[0] && chain_rec[0].equal) |-> !chain_rec[0].less && !chain_rec[0].greater)
        else $error("equal with less or greater");

endmodule
